### hdl/ula_pkg.sv
package ula_pkg;

    // Fixed field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned KIND_W = 2;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // Request opcodes
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_NOTICE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_error;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] data_byte;
        logic [CNT_W-1:0]  line_length;
        logic              truncated;
        logic              last;
    } rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_STREAM
    } state_t;

endpackage

### hdl/uart_line_assembler.sv
// Character beats: on a terminator, a line-ready notice is valid the next cycle.
// Read beats: "no line" is valid the next cycle; a line of N bytes streams one byte per
// cycle while the output is not stalled, set by the single read port of the line memory;
// the next request is taken after the last byte loads.
// Reset clears counts, flags and the ready mark; the line memory is not cleared.
module uart_line_assembler #(
    parameter int unsigned LINE_MAX = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ula_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ula_pkg::rsp_t rsp
);

    localparam int unsigned IDX_W  = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;
    localparam int unsigned ADDR_W = IDX_W + 1;

    ula_pkg::state_t state_reg, state_next;

    logic                      bank_reg, bank_next;        // bank holding the frozen line
    logic [ula_pkg::CNT_W-1:0] accum_count_reg, accum_count_next;
    logic                      accum_ovf_reg, accum_ovf_next;
    logic [ula_pkg::CNT_W-1:0] ready_count_reg, ready_count_next;
    logic                      ready_trunc_reg, ready_trunc_next;
    logic                      ready_valid_reg, ready_valid_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    ula_pkg::rsp_t             rsp_reg, rsp_next;

    logic                       out_free;
    logic                       accept;
    logic                       is_term;
    logic                       stream_last;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [ula_pkg::BYTE_W-1:0] rd_data;

    ula_linebuf #(
        .ADDR_W (ADDR_W)
    ) u_linebuf (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.rx_byte),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign req_stall   = !((state_reg == ula_pkg::ST_IDLE) && out_free);
    assign accept      = req_valid && !req_stall;
    assign is_term     = (req.rx_byte == ula_pkg::CH_CR) || (req.rx_byte == ula_pkg::CH_LF);
    assign stream_last = ((ula_pkg::CNT_W'(idx_reg) + 7'd1) == ready_count_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ula_pkg::ST_IDLE:
            begin
                if (accept && (req.opcode == ula_pkg::OP_READ) && ready_valid_reg)
                begin
                    state_next = ula_pkg::ST_STREAM;
                end
            end
            ula_pkg::ST_STREAM:
            begin
                if (out_free && stream_last)
                begin
                    state_next = ula_pkg::ST_IDLE;
                end
            end
            default: state_next = ula_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory control and result loading
    always_comb
    begin
        bank_next        = bank_reg;
        accum_count_next = accum_count_reg;
        accum_ovf_next   = accum_ovf_reg;
        ready_count_next = ready_count_reg;
        ready_trunc_next = ready_trunc_reg;
        ready_valid_next = ready_valid_reg;
        idx_next         = idx_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        rsp_next         = rsp_reg;
        wr_en            = 1'b0;
        wr_addr          = {~bank_reg, accum_count_reg[IDX_W-1:0]};
        rd_en            = 1'b0;
        rd_addr          = {bank_reg, idx_reg};

        unique case (state_reg)
            ula_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.opcode == ula_pkg::OP_READ)
                    begin
                        if (ready_valid_reg)
                        begin
                            // start the stream at entry zero
                            rd_en    = 1'b1;
                            rd_addr  = {bank_reg, {IDX_W{1'b0}}};
                            idx_next = '0;
                        end
                        else
                        begin
                            rsp_valid_next       = 1'b1;
                            rsp_next.kind        = ula_pkg::KIND_NONE;
                            rsp_next.data_byte   = '0;
                            rsp_next.line_length = '0;
                            rsp_next.truncated   = 1'b0;
                            rsp_next.last        = 1'b1;
                        end
                    end
                    else if (!req.rx_error)
                    begin
                        if (is_term)
                        begin
                            if (accum_count_reg != '0)
                            begin
                                // freeze: swap banks, no copy
                                bank_next            = ~bank_reg;
                                ready_count_next     = accum_count_reg;
                                ready_trunc_next     = accum_ovf_reg;
                                ready_valid_next     = 1'b1;
                                accum_count_next     = '0;
                                accum_ovf_next       = 1'b0;
                                rsp_valid_next       = 1'b1;
                                rsp_next.kind        = ula_pkg::KIND_NOTICE;
                                rsp_next.data_byte   = '0;
                                rsp_next.line_length = accum_count_reg;
                                rsp_next.truncated   = accum_ovf_reg;
                                rsp_next.last        = 1'b1;
                            end
                        end
                        else if (accum_count_reg < ula_pkg::CNT_W'(LINE_MAX))
                        begin
                            wr_en            = 1'b1;
                            accum_count_next = accum_count_reg + 7'd1;
                        end
                        else
                        begin
                            accum_ovf_next = 1'b1;
                        end
                    end
                end
            end
            ula_pkg::ST_STREAM:
            begin
                if (out_free)
                begin
                    rsp_valid_next       = 1'b1;
                    rsp_next.kind        = ula_pkg::KIND_BYTE;
                    rsp_next.data_byte   = rd_data;
                    rsp_next.line_length = ready_count_reg;
                    rsp_next.truncated   = ready_trunc_reg;
                    rsp_next.last        = stream_last;
                    if (stream_last)
                    begin
                        ready_valid_next = 1'b0;
                        ready_trunc_next = 1'b0;
                    end
                    else
                    begin
                        // fetch the following byte while this one goes out
                        idx_next = idx_reg + IDX_W'(1);
                        rd_en    = 1'b1;
                        rd_addr  = {bank_reg, idx_reg + IDX_W'(1)};
                    end
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && rsp_stall;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ula_pkg::ST_IDLE;
            bank_reg        <= 1'b0;
            accum_count_reg <= '0;
            accum_ovf_reg   <= 1'b0;
            ready_count_reg <= '0;
            ready_trunc_reg <= 1'b0;
            ready_valid_reg <= 1'b0;
            idx_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bank_reg        <= bank_next;
            accum_count_reg <= accum_count_next;
            accum_ovf_reg   <= accum_ovf_next;
            ready_count_reg <= ready_count_next;
            ready_trunc_reg <= ready_trunc_next;
            ready_valid_reg <= ready_valid_next;
            idx_reg         <= idx_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    a_stream_has_line: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ula_pkg::ST_STREAM) |-> ready_valid_reg)
        else $error("stream running without a ready line");

    a_accum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        accum_count_reg <= ula_pkg::CNT_W'(LINE_MAX))
        else $error("accumulator count past line size");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ula_pkg::ST_STREAM) |-> (ula_pkg::CNT_W'(idx_reg) < ready_count_reg))
        else $error("stream index past line length");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_stall && (rsp.kind == ula_pkg::KIND_BYTE) && rsp.last)
        |-> !ready_valid_reg)
        else $error("ready mark kept after final line byte");

endmodule

### hdl/ula_linebuf.sv
// Two-bank line memory: one bank collects, the other holds the frozen line.
module ula_linebuf #(
    parameter int unsigned ADDR_W = 7
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [ula_pkg::BYTE_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [ula_pkg::BYTE_W-1:0] rd_data
);

    logic [ula_pkg::BYTE_W-1:0] mem [2**ADDR_W];
    logic [ula_pkg::BYTE_W-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### tb/uart_line_assembler_test.sv
`timescale 1ns / 1ps

module uart_line_assembler_test;

    localparam int LINE_MAX     = 64;
    localparam int RANDOM_BEATS = 16;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 20;
    localparam longint TIMEOUT_NS = 40000000;

    // Line buffer predictor and the queue of results it expects
    class line_scoreboard;
        logic [ula_pkg::BYTE_W-1:0] accum_mem [LINE_MAX];
        int                         pend_len;
        bit                         accum_ovf;
        logic [ula_pkg::BYTE_W-1:0] line_mem [LINE_MAX];
        int                         line_len;
        bit                         line_trunc;
        bit                         line_ready;
        ula_pkg::rsp_t              expected_q [$];
        int                         fail_count;
        int                         checked;
        int                         frozen;
        int                         frozen_trunc;
        int                         lines_read;
        int                         empty_reads;

        function new();
            pend_len     = 0;
            accum_ovf    = 0;
            line_len     = 0;
            line_trunc   = 0;
            line_ready   = 0;
            fail_count   = 0;
            checked      = 0;
            frozen       = 0;
            frozen_trunc = 0;
            lines_read   = 0;
            empty_reads  = 0;
        endfunction

        function ula_pkg::rsp_t make_rsp(logic [ula_pkg::KIND_W-1:0] kind,
                                         logic [ula_pkg::BYTE_W-1:0] data,
                                         int len, bit trunc, bit fin);
            ula_pkg::rsp_t r;
            r.kind        = kind;
            r.data_byte   = data;
            r.line_length = ula_pkg::CNT_W'(len);
            r.truncated   = trunc;
            r.last        = fin;
            return r;
        endfunction

        // Work out the results caused by one accepted request beat
        function void note_request(ula_pkg::req_t r);
            if (r.opcode == ula_pkg::OP_READ)
            begin
                if (!line_ready)
                begin
                    expected_q.push_back(make_rsp(ula_pkg::KIND_NONE, '0, 0, 1'b0, 1'b1));
                    empty_reads++;
                end
                else
                begin
                    for (int i = 0; i < line_len; i++)
                        expected_q.push_back(make_rsp(ula_pkg::KIND_BYTE, line_mem[i],
                                                      line_len, line_trunc,
                                                      i == line_len - 1));
                    line_ready = 0;
                    line_trunc = 0;
                    lines_read++;
                end
            end
            else if (r.rx_error)
            begin
                // errored character: dropped
            end
            else if (r.rx_byte == ula_pkg::CH_CR || r.rx_byte == ula_pkg::CH_LF)
            begin
                if (pend_len != 0)
                begin
                    for (int i = 0; i < pend_len; i++)
                        line_mem[i] = accum_mem[i];
                    line_len   = pend_len;
                    line_trunc = accum_ovf;
                    line_ready = 1;
                    pend_len   = 0;
                    accum_ovf  = 0;
                    expected_q.push_back(make_rsp(ula_pkg::KIND_NOTICE, '0, line_len,
                                                  line_trunc, 1'b1));
                    frozen++;
                    if (line_trunc)
                        frozen_trunc++;
                end
            end
            else if (pend_len < LINE_MAX)
            begin
                accum_mem[pend_len] = r.rx_byte;
                pend_len++;
            end
            else
            begin
                accum_ovf = 1;
            end
        endfunction

        function void report_field(string name, logic [7:0] want, logic [7:0] got);
            $display("%0t: mismatch on %s: expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        endfunction

        // Compare one accepted result beat with the oldest expectation
        function void check_response(ula_pkg::rsp_t got);
            ula_pkg::rsp_t want;
            checked++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result: kind %0h data %0h len %0h trunc %0h last %0h",
                         $time, got.kind, got.data_byte, got.line_length, got.truncated,
                         got.last);
                fail_count++;
                return;
            end
            want = expected_q.pop_front();
            if (got.kind !== want.kind)
                report_field("kind", 8'(want.kind), 8'(got.kind));
            if (got.data_byte !== want.data_byte)
                report_field("data_byte", want.data_byte, got.data_byte);
            if (got.line_length !== want.line_length)
                report_field("line_length", 8'(want.line_length), 8'(got.line_length));
            if (got.truncated !== want.truncated)
                report_field("truncated", 8'(want.truncated), 8'(got.truncated));
            if (got.last !== want.last)
                report_field("last", 8'(want.last), 8'(got.last));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    ula_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    ula_pkg::rsp_t rsp;

    line_scoreboard board = new();
    bit quiet      = 0;
    bit hold_req   = 0;
    bit hold_taken = 0;
    int beats_sent = 0;

    uart_line_assembler #(
        .LINE_MAX (LINE_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sender idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic ula_pkg::req_t char_beat(logic [ula_pkg::BYTE_W-1:0] b, logic err);
        ula_pkg::req_t r;
        r.opcode   = ula_pkg::OP_CHAR;
        r.rx_byte  = b;
        r.rx_error = err;
        return r;
    endfunction

    // Read request; the other fields are don't-care and get random values
    function automatic ula_pkg::req_t read_beat();
        ula_pkg::req_t r;
        r.opcode   = ula_pkg::OP_READ;
        r.rx_byte  = 8'($urandom_range(0, 255));
        r.rx_error = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic logic [ula_pkg::BYTE_W-1:0] plain_byte();
        logic [ula_pkg::BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == ula_pkg::CH_CR || b == ula_pkg::CH_LF);
        return b;
    endfunction

    // Offer one request beat and wait until it is taken
    task automatic send_beat(ula_pkg::req_t r, int gap);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(r);
        beats_sent++;
    endtask

    // A line of len plain bytes with optional dropped errored bytes, then a terminator
    task automatic send_line(int len, int err_pct, bit zero_gap);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 99) < err_pct)
                send_beat(char_beat(8'($urandom_range(0, 255)), 1'b1),
                          zero_gap ? 0 : pick_gap());
            send_beat(char_beat(plain_byte(), 1'b0), zero_gap ? 0 : pick_gap());
        end
        send_beat(char_beat($urandom_range(0, 1) ? ula_pkg::CH_CR : ula_pkg::CH_LF, 1'b0),
                  zero_gap ? 0 : pick_gap());
    endtask

    // Result side: check accepted beats, drive stall
    initial
    begin
        int stall_left;
        int hold_left;
        int r;
        stall_left = 0;
        hold_left  = 0;
        rsp_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid && !rsp_stall)
                board.check_response(rsp);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (quiet)
                rsp_stall <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 72)
                    rsp_stall <= 1'b0;
                else if (r < 96)
                begin
                    stall_left = $urandom_range(0, 2);
                    rsp_stall  <= 1'b1;
                end
                else
                begin
                    stall_left = $urandom_range(15, 50);
                    rsp_stall  <= 1'b1;
                end
            end
        end
    end

    // Stimulus
    initial
    begin
        int random_beats;
        int r;
        int len;
        bit leftover;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty read, ignored terminators, errors, short lines, overwrite
        send_beat('{opcode: ula_pkg::OP_READ, rx_byte: 8'hFF, rx_error: 1'b1}, 0);
        send_beat(char_beat(ula_pkg::CH_CR, 1'b0), pick_gap());
        send_beat(char_beat(ula_pkg::CH_LF, 1'b0), pick_gap());
        send_beat(char_beat(8'h00, 1'b1), pick_gap());
        send_beat(char_beat(ula_pkg::CH_CR, 1'b1), pick_gap());
        send_beat(char_beat(8'h00, 1'b0), pick_gap());
        send_beat(char_beat(8'hFF, 1'b0), pick_gap());
        send_beat(char_beat(ula_pkg::CH_LF, 1'b1), pick_gap());
        send_beat(char_beat(8'h41, 1'b0), pick_gap());
        send_beat(char_beat(ula_pkg::CH_CR, 1'b0), pick_gap());
        send_beat('{opcode: ula_pkg::OP_READ, rx_byte: 8'h00, rx_error: 1'b0}, pick_gap());
        send_beat(read_beat(), pick_gap());
        send_beat(char_beat(8'h7E, 1'b0), pick_gap());
        send_beat(char_beat(ula_pkg::CH_LF, 1'b0), pick_gap());
        // uncollected line gets replaced
        send_beat(char_beat(8'h55, 1'b0), pick_gap());
        send_beat(char_beat(8'hAA, 1'b0), pick_gap());
        send_beat(char_beat(ula_pkg::CH_LF, 1'b0), pick_gap());
        send_beat('{opcode: ula_pkg::OP_READ, rx_byte: ula_pkg::CH_CR, rx_error: 1'b0},
                  pick_gap());
        send_beat(char_beat(ula_pkg::CH_LF, 1'b0), pick_gap());
        send_beat(read_beat(), pick_gap());

        // Long receiver hold while a full-length line is assembled and read back
        req_valid <= 1'b0;
        @(posedge clk);
        hold_req = 1;
        send_line(LINE_MAX, 0, 1'b1);
        send_beat(read_beat(), 0);
        send_line(3, 0, 1'b1);
        send_beat(read_beat(), 0);
        send_beat(read_beat(), 0);

        // No idling on either side; an overflowing line
        quiet = 1;
        send_line(LINE_MAX + 3, 5, 1'b1);
        send_beat(char_beat(ula_pkg::CH_CR, 1'b0), 0);
        send_beat(read_beat(), 0);
        send_line(2, 0, 1'b1);
        send_beat(read_beat(), 0);
        quiet = 0;

        // Random mix: mostly well-formed lines, some reads and noise
        random_beats = 0;
        while (random_beats < RANDOM_BEATS)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                send_beat('{opcode: 1'($urandom_range(0, 1)),
                            rx_byte: 8'($urandom_range(0, 255)),
                            rx_error: 1'($urandom_range(0, 1))}, pick_gap());
                random_beats++;
            end
            else if (r < 22)
            begin
                send_beat(read_beat(), pick_gap());
                random_beats++;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    len = $urandom_range(LINE_MAX - 4, LINE_MAX + 4);
                else
                    len = $urandom_range(0, 7);
                if (r > 94)
                    quiet = 1;
                send_line(len, 10, 1'b0);
                random_beats += len + 1;
                if ($urandom_range(0, 99) < 60)
                begin
                    send_beat(read_beat(), pick_gap());
                    random_beats++;
                end
                quiet = 0;
            end
        end
        req_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        for (int i = 0; i < DRAIN_LIMIT && board.expected_q.size() != 0; i++)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        leftover = board.expected_q.size() != 0;
        if (leftover)
            $display("%0t: %0d expected results never arrived", $time,
                     board.expected_q.size());

        $display("Sent %0d request beats; %0d lines frozen, %0d of them truncated",
                 beats_sent, board.frozen, board.frozen_trunc);
        $display("%0d lines read, %0d empty reads, %0d results checked, %0d mismatches",
                 board.lines_read, board.empty_reads, board.checked, board.fail_count);
        if (board.fail_count == 0 && !leftover)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
